// ===== hdl/pcr_pkg.sv =====
// pcr_pkg: shared types, constants and helpers of the per-channel resequencer
// depends on nothing; used by pcr_front, pcr_back and per_channel_resequencer

package pcr_pkg;

	localparam int unsigned SEQ_W = 31;
	localparam int unsigned TAG_W = 16;
	localparam int unsigned CH_W = 6;
	localparam int unsigned CH_CODES = 64;
	localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

	// result outcome codes
	typedef enum logic [1:0] {
		OUT_PUB = 2'd0,
		OUT_HELD = 2'd1,
		OUT_DROP = 2'd2
	} outcome_t;

	// front state machine
	typedef enum logic {
		F_IDLE = 1'b0,
		F_LOOK = 1'b1
	} front_state_t;

	// fixed part of a command passed from front to back
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [CH_W-1:0] ch;
		logic [SEQ_W-1:0] seq;
		outcome_t outcome;
	} cmd_t;

	// sequence increment, zero is skipped
	function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] s);
		logic [SEQ_W-1:0] n;
		n = (s == SEQ_MAX) ? SEQ_W'(1) : s + SEQ_W'(1);
		return n;
	endfunction

endpackage

// ===== hdl/pcr_queue.sv =====
// pcr_queue: two-entry command queue between front and back
// depends on nothing outside this file

module pcr_queue #(
	parameter int unsigned DW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [DW-1:0] din,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output logic [DW-1:0] dout
);

	logic [DW-1:0] mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign dout = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

// ===== hdl/pcr_front.sv =====
// pcr_front: accepts requests, looks up channel state and classifies them
// depends on pcr_pkg; writes tags into the back's tag store

module pcr_front #(
	parameter int unsigned CHANNELS = 64,
	parameter int unsigned WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pcr_pkg::SEQ_W-1:0] cfg_wdata,
	input  logic req_valid,
	output logic req_ready,
	input  logic [pcr_pkg::CH_W-1:0] channel,
	input  logic [pcr_pkg::SEQ_W-1:0] sequence_req,
	input  logic [pcr_pkg::TAG_W-1:0] message_tag,
	input  logic q_full,
	input  logic multi_done,
	output logic push,
	output pcr_pkg::cmd_t cmd,
	output logic [$clog2(WINDOW+1)-1:0] cmd_cnt,
	output logic [$clog2(CHANNELS*WINDOW)-1:0] cmd_base,
	output logic [$clog2(WINDOW)-1:0] cmd_slot,
	output logic tag_we,
	output logic [$clog2(CHANNELS*WINDOW)-1:0] tag_waddr,
	output logic [pcr_pkg::TAG_W-1:0] tag_wdata
);

	localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned WW = $clog2(WINDOW);
	localparam int unsigned CNTW = $clog2(WINDOW+1);
	localparam int unsigned AW = $clog2(CHANNELS*WINDOW);
	localparam int unsigned SW = pcr_pkg::SEQ_W;

	typedef struct packed {
		logic [SW-1:0] exp;
		logic [WW-1:0] head;
		logic [WINDOW-1:0] vrow;
	} chst_t;

	pcr_pkg::front_state_t state_q, state_d;
	logic [SW-1:0] init_q;
	logic [CHANNELS-1:0] seen_q;
	logic pend_q;

	chst_t chmem [CHANNELS];
	chst_t rd_s1;
	logic [pcr_pkg::CH_W-1:0] ch_s1;
	logic [CW-1:0] c_s1;
	logic [SW-1:0] seq_s1;
	logic [pcr_pkg::TAG_W-1:0] tag_s1;

	logic accept;
	logic [CW-1:0] c_in;
	logic sequenced;
	logic [SW-1:0] exp;
	logic [WW-1:0] head;
	logic [WINDOW-1:0] vrow;
	logic [SW-1:0] seq_eff;
	logic [SW-1:0] off;
	logic drop;
	logic release_run;
	logic [WW:0] slot_sum;
	logic [WW-1:0] slot;
	logic [WINDOW-1:0] vset;
	logic [2*WINDOW-1:0] dbl;
	logic [WINDOW-1:0] rot;
	logic [CNTW-1:0] cnt;
	logic [WINDOW-1:0] vnew;
	logic [WW:0] gap;
	logic [WW:0] head_sum;
	logic [WW:0] head_inc;
	logic [SW:0] exp_sum;
	logic [SW-1:0] exp_new;
	chst_t wr_ent;
	logic mem_we;
	logic multi_push;

	// channel index folded onto the configured channel count
	always_comb begin
		c_in = '0;
		for (int i = 0; i < pcr_pkg::CH_CODES; i++) begin
			if (channel == pcr_pkg::CH_W'(i))
				c_in = CW'(i % CHANNELS);
		end
	end

	assign accept = req_valid && req_ready;

	// state register and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcr_pkg::F_IDLE;
			init_q <= SW'(1);
			seen_q <= '0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				init_q <= cfg_wdata;
			if (mem_we)
				seen_q[c_s1] <= 1'b1;
			if (multi_push)
				pend_q <= 1'b1;
			else if (multi_done)
				pend_q <= 1'b0;
		end
	end

	// next state and handshake
	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		push = 1'b0;
		unique case (state_q)
			pcr_pkg::F_IDLE: begin
				req_ready = !q_full && !pend_q;
				if (req_valid && req_ready)
					state_d = pcr_pkg::F_LOOK;
			end
			pcr_pkg::F_LOOK: begin
				push = 1'b1;
				state_d = pcr_pkg::F_IDLE;
			end
			default: state_d = pcr_pkg::F_IDLE;
		endcase
	end

	// request capture and channel state read
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= channel;
			c_s1 <= c_in;
			seq_s1 <= sequence_req;
			tag_s1 <= message_tag;
			rd_s1 <= chmem[c_in];
		end
		if (mem_we)
			chmem[c_s1] <= wr_ent;
	end

	// classification of the captured request
	always_comb begin
		sequenced = (seq_s1 != '0);
		if (seen_q[c_s1]) begin
			exp = rd_s1.exp;
			head = rd_s1.head;
			vrow = rd_s1.vrow;
		end else begin
			exp = (init_q == '0) ? SW'(1) : init_q;
			head = '0;
			vrow = '0;
		end
		seq_eff = (seq_s1 < exp) ? exp : seq_s1;
		off = seq_eff - exp;
		drop = (off >= SW'(WINDOW));
		release_run = !drop && (off == '0);
		slot_sum = {1'b0, head} + {1'b0, off[WW-1:0]};
		if (slot_sum >= (WW+1)'(WINDOW))
			slot_sum = slot_sum - (WW+1)'(WINDOW);
		slot = slot_sum[WW-1:0];
		vset = vrow | (WINDOW'(1) << slot);
	end

	// length of the run released from the head
	always_comb begin
		dbl = {vset, vset} >> head;
		rot = dbl[WINDOW-1:0];
		cnt = CNTW'(WINDOW);
		for (int i = WINDOW-1; i >= 0; i--) begin
			if (!rot[i])
				cnt = CNTW'(i);
		end
	end

	// valid row with the released run cleared
	always_comb begin
		vnew = vset;
		gap = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if ((WW+1)'(i) >= {1'b0, head})
				gap = (WW+1)'(i) - {1'b0, head};
			else
				gap = (WW+1)'(i) + (WW+1)'(WINDOW) - {1'b0, head};
			if (gap < (WW+1)'(cnt))
				vnew[i] = 1'b0;
		end
	end

	// head and expected number after the run
	always_comb begin
		head_sum = {1'b0, head} + (WW+1)'(cnt);
		if (head_sum >= (WW+1)'(WINDOW))
			head_sum = head_sum - (WW+1)'(WINDOW);
		head_inc = {1'b0, head} + (WW+1)'(1);
		if (head_inc >= (WW+1)'(WINDOW))
			head_inc = head_inc - (WW+1)'(WINDOW);
		exp_sum = {1'b0, exp} + (SW+1)'(cnt);
		if (exp_sum > {1'b0, pcr_pkg::SEQ_MAX})
			exp_sum = exp_sum - {1'b0, pcr_pkg::SEQ_MAX};
		exp_new = exp_sum[SW-1:0];
	end

	// channel state update, tag write and command
	always_comb begin
		mem_we = push && sequenced;
		wr_ent.exp = exp;
		wr_ent.head = head;
		wr_ent.vrow = vrow;
		if (release_run) begin
			wr_ent.exp = exp_new;
			wr_ent.head = head_sum[WW-1:0];
			wr_ent.vrow = vnew;
		end else if (!drop) begin
			wr_ent.vrow = vset;
		end
		tag_we = push && sequenced && !drop;
		tag_waddr = AW'(int'(c_s1) * WINDOW + int'(slot));
		tag_wdata = tag_s1;

		cmd.tag = '0;
		cmd.ch = ch_s1;
		cmd.seq = seq_eff;
		cmd.outcome = pcr_pkg::OUT_HELD;
		cmd_cnt = CNTW'(1);
		cmd_base = AW'(int'(c_s1) * WINDOW);
		cmd_slot = head_inc[WW-1:0];
		if (!sequenced) begin
			cmd.tag = tag_s1;
			cmd.seq = '0;
			cmd.outcome = pcr_pkg::OUT_PUB;
		end else if (drop) begin
			cmd.outcome = pcr_pkg::OUT_DROP;
		end else if (release_run) begin
			cmd.tag = tag_s1;
			cmd.seq = exp;
			cmd.outcome = pcr_pkg::OUT_PUB;
			cmd_cnt = cnt;
		end
		multi_push = push && sequenced && release_run && (cnt > CNTW'(1));
	end

	// only one multi-message run may be outstanding in the back
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		multi_push |-> !pend_q)
		else $error("second multi-message run pushed while one pending");

endmodule

// ===== hdl/pcr_back.sv =====
// pcr_back: holds the tag store and delivers results from queued commands
// depends on pcr_pkg; fed by pcr_front through pcr_queue

module pcr_back #(
	parameter int unsigned CHANNELS = 64,
	parameter int unsigned WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic tag_we,
	input  logic [$clog2(CHANNELS*WINDOW)-1:0] tag_waddr,
	input  logic [pcr_pkg::TAG_W-1:0] tag_wdata,
	input  logic q_nonempty,
	output logic q_pop,
	input  pcr_pkg::cmd_t q_cmd,
	input  logic [$clog2(WINDOW+1)-1:0] q_cnt,
	input  logic [$clog2(CHANNELS*WINDOW)-1:0] q_base,
	input  logic [$clog2(WINDOW)-1:0] q_slot,
	output logic multi_done,
	output logic rsp_valid,
	input  logic rsp_ready,
	output logic [pcr_pkg::TAG_W-1:0] out_tag,
	output logic [pcr_pkg::CH_W-1:0] out_channel,
	output logic [pcr_pkg::SEQ_W-1:0] out_sequence,
	output logic [1:0] outcome,
	output logic last
);

	localparam int unsigned WW = $clog2(WINDOW);
	localparam int unsigned CNTW = $clog2(WINDOW+1);
	localparam int unsigned AW = $clog2(CHANNELS*WINDOW);

	logic [pcr_pkg::TAG_W-1:0] tmem [CHANNELS*WINDOW];
	logic [pcr_pkg::TAG_W-1:0] rd_q;

	logic run_q;
	logic first_q;
	logic multi_q;
	pcr_pkg::cmd_t cmd_q;
	logic [CNTW-1:0] rem_q;
	logic [AW-1:0] base_q;
	logic [WW-1:0] slot_q;
	logic out_valid_q;

	logic out_free;
	logic emit;
	logic [WW:0] slot_inc;
	logic [WW-1:0] slot_d;
	logic [AW-1:0] base_d;
	logic [AW-1:0] raddr;

	assign out_free = !out_valid_q || rsp_ready;
	assign emit = run_q && out_free;
	assign q_pop = !run_q && q_nonempty;
	assign multi_done = emit && (rem_q == CNTW'(1)) && multi_q;
	assign rsp_valid = out_valid_q;

	// next read slot, so read data lines up with the emitting slot
	always_comb begin
		slot_inc = {1'b0, slot_q} + (WW+1)'(1);
		if (slot_inc >= (WW+1)'(WINDOW))
			slot_inc = slot_inc - (WW+1)'(WINDOW);
		slot_d = slot_q;
		base_d = base_q;
		if (q_pop) begin
			slot_d = q_slot;
			base_d = q_base;
		end else if (emit && !first_q) begin
			slot_d = slot_inc[WW-1:0];
		end
		raddr = base_d + AW'(slot_d);
	end

	// tag store
	always_ff @(posedge clk) begin
		if (tag_we)
			tmem[tag_waddr] <= tag_wdata;
		rd_q <= tmem[raddr];
	end

	// run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				run_q <= 1'b1;
			else if (emit && rem_q == CNTW'(1))
				run_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers of the current command
	always_ff @(posedge clk) begin
		base_q <= base_d;
		slot_q <= slot_d;
		if (q_pop) begin
			cmd_q <= q_cmd;
			rem_q <= q_cnt;
			first_q <= 1'b1;
			multi_q <= (q_cnt > CNTW'(1));
		end else if (emit) begin
			rem_q <= rem_q - CNTW'(1);
			first_q <= 1'b0;
			cmd_q.seq <= pcr_pkg::next_seq(cmd_q.seq);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_tag <= first_q ? cmd_q.tag : rd_q;
			out_channel <= cmd_q.ch;
			out_sequence <= cmd_q.seq;
			outcome <= cmd_q.outcome;
			last <= (rem_q == CNTW'(1));
		end
	end

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> rem_q != '0)
		else $error("active run with nothing left to deliver");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && rem_q == CNTW'(1)) |=> !run_q)
		else $error("run continues after its last result");

endmodule

// ===== hdl/per_channel_resequencer.sv =====
// per_channel_resequencer: top level, front classifier, command queue, back deliverer
// path: request captured by the front, queued, taken by the back, result registered
// flow: the front takes no new request while one is being looked up; requests
// also wait while the queue is full or while a released run of more than one drains
// reset: clears channel state, sets initial_sequence to 1; tag store is not cleared
// depends on pcr_pkg, pcr_front, pcr_queue, pcr_back

module per_channel_resequencer #(
	parameter int unsigned CHANNELS = 64,
	parameter int unsigned WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pcr_pkg::SEQ_W-1:0] cfg_wdata,
	input  logic req_valid,
	output logic req_ready,
	input  logic [pcr_pkg::CH_W-1:0] channel,
	input  logic [pcr_pkg::SEQ_W-1:0] sequence_req,
	input  logic [pcr_pkg::TAG_W-1:0] message_tag,
	output logic rsp_valid,
	input  logic rsp_ready,
	output logic [pcr_pkg::TAG_W-1:0] out_tag,
	output logic [pcr_pkg::CH_W-1:0] out_channel,
	output logic [pcr_pkg::SEQ_W-1:0] out_sequence,
	output logic [1:0] outcome,
	output logic last
);

	localparam int unsigned WW = $clog2(WINDOW);
	localparam int unsigned CNTW = $clog2(WINDOW+1);
	localparam int unsigned AW = $clog2(CHANNELS*WINDOW);
	localparam int unsigned DW = $bits(pcr_pkg::cmd_t) + CNTW + AW + WW;

	logic push;
	logic q_full;
	logic q_nonempty;
	logic q_pop;
	logic multi_done;
	pcr_pkg::cmd_t f_cmd;
	pcr_pkg::cmd_t b_cmd;
	logic [CNTW-1:0] f_cnt, b_cnt;
	logic [AW-1:0] f_base, b_base;
	logic [WW-1:0] f_slot, b_slot;
	logic tag_we;
	logic [AW-1:0] tag_waddr;
	logic [pcr_pkg::TAG_W-1:0] tag_wdata;
	logic [DW-1:0] q_din, q_dout;

	assign q_din = {f_cmd, f_cnt, f_base, f_slot};
	assign {b_cmd, b_cnt, b_base, b_slot} = q_dout;

	pcr_front #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_ready(req_ready),
		.channel(channel), .sequence_req(sequence_req), .message_tag(message_tag),
		.q_full(q_full), .multi_done(multi_done), .push(push),
		.cmd(f_cmd), .cmd_cnt(f_cnt), .cmd_base(f_base), .cmd_slot(f_slot),
		.tag_we(tag_we), .tag_waddr(tag_waddr), .tag_wdata(tag_wdata)
	);

	pcr_queue #(.DW(DW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(q_din), .full(q_full),
		.pop(q_pop), .nonempty(q_nonempty), .dout(q_dout)
	);

	pcr_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.tag_we(tag_we), .tag_waddr(tag_waddr), .tag_wdata(tag_wdata),
		.q_nonempty(q_nonempty), .q_pop(q_pop),
		.q_cmd(b_cmd), .q_cnt(b_cnt), .q_base(b_base), .q_slot(b_slot),
		.multi_done(multi_done),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.out_tag(out_tag), .out_channel(out_channel), .out_sequence(out_sequence),
		.outcome(outcome), .last(last)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for per_channel_resequencer, with predictor, driver and monitor
// depends on pcr_pkg and the per_channel_resequencer rtl

module tb_top;

	localparam int CHANS = 64;
	localparam int WIN = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int CHW = pcr_pkg::CH_W;
	localparam int SQW = pcr_pkg::SEQ_W;
	localparam int TGW = pcr_pkg::TAG_W;

	typedef struct packed {
		logic [CHW-1:0] ch;
		logic [SQW-1:0] seq;
		logic [TGW-1:0] tag;
	} request_t;

	typedef struct packed {
		logic [TGW-1:0] tag;
		logic [CHW-1:0] ch;
		logic [SQW-1:0] seq;
		pcr_pkg::outcome_t res;
		logic fin;
	} release_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SQW-1:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [CHW-1:0] channel = '0;
	logic [SQW-1:0] sequence_req = '0;
	logic [TGW-1:0] message_tag = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [TGW-1:0] out_tag;
	logic [CHW-1:0] out_channel;
	logic [SQW-1:0] out_sequence;
	logic [1:0] outcome;
	logic last;

	per_channel_resequencer #(.CHANNELS(CHANS), .WINDOW(WIN)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_ready(req_ready), .channel(channel),
		.sequence_req(sequence_req), .message_tag(message_tag),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .out_tag(out_tag),
		.out_channel(out_channel), .out_sequence(out_sequence),
		.outcome(outcome), .last(last)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [SQW-1:0] start_seq = SQW'(1);
	logic seen [CHANS] = '{default: 1'b0};
	logic [SQW-1:0] next_expected [CHANS] = '{default: '0};
	int ring_head [CHANS] = '{default: 0};
	logic held [CHANS*WIN] = '{default: 1'b0};
	logic [TGW-1:0] held_tag [CHANS*WIN] = '{default: '0};

	request_t pending_reqs[$];
	release_t expected_releases[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_trig = 0;
	int hold_seen = 0;
	int hold_off = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	function automatic logic [SQW-1:0] seq_after(input logic [SQW-1:0] s);
		logic [SQW-1:0] n;
		n = s + 1'b1;
		return (n == '0) ? SQW'(1) : n;
	endfunction

	// work out the releases caused by one accepted request
	task automatic predict_release(input request_t r);
		int c;
		int slot;
		int h;
		logic [SQW-1:0] s;
		logic [SQW-1:0] off;
		release_t e;
		c = r.ch % CHANS;
		s = r.seq;
		if (s == '0) begin
			e = '{r.tag, r.ch, '0, pcr_pkg::OUT_PUB, 1'b1};
			expected_releases.push_back(e);
			return;
		end
		if (!seen[c]) begin
			seen[c] = 1;
			next_expected[c] = (start_seq == '0) ? SQW'(1) : start_seq;
			ring_head[c] = 0;
		end
		if (s < next_expected[c]) s = next_expected[c];
		off = s - next_expected[c];
		if (off >= WIN) begin
			e = '{'0, r.ch, s, pcr_pkg::OUT_DROP, 1'b1};
			expected_releases.push_back(e);
			return;
		end
		slot = c * WIN + (ring_head[c] + int'(off)) % WIN;
		held[slot] = 1;
		held_tag[slot] = r.tag;
		if (off != 0) begin
			e = '{'0, r.ch, s, pcr_pkg::OUT_HELD, 1'b1};
			expected_releases.push_back(e);
			return;
		end
		for (int n = 0; n < WIN; n++) begin
			h = c * WIN + ring_head[c];
			if (!held[h]) break;
			if (n > 0) expected_releases[$].fin = 1'b0;
			e = '{held_tag[h], r.ch, next_expected[c], pcr_pkg::OUT_PUB, 1'b1};
			expected_releases.push_back(e);
			held[h] = 0;
			ring_head[c] = (ring_head[c] + 1) % WIN;
			next_expected[c] = seq_after(next_expected[c]);
		end
	endtask

	// driver: offers queued requests, idling at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_release('{channel, sequence_req, message_tag});
			end
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					req_valid <= 1'b1;
					channel <= pending_reqs[0].ch;
					sequence_req <= pending_reqs[0].seq;
					message_tag <= pending_reqs[0].tag;
					void'(pending_reqs.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_off <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: compare each release with the oldest expectation
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (expected_releases.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected release tag %h ch %0d seq %0d", out_tag,
						out_channel, out_sequence);
			end else begin
				release_t e;
				e = expected_releases.pop_front();
				if (out_tag !== e.tag || out_channel !== e.ch || out_sequence !== e.seq ||
					outcome !== e.res || last !== e.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp %h %0d %0d %0d %0d, got %h %0d %0d %0d %0d",
							e.tag, e.ch, e.seq, e.res, e.fin, out_tag, out_channel,
							out_sequence, outcome, last);
				end
			end
		end
	end

	// watchdog on cycles with no request or release moving
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("per_channel_resequencer: mismatch");
			$finish;
		end
	end

	task automatic add_req(input int ch, input longint seq, input int tag);
		pending_reqs.push_back('{CHW'(ch), SQW'(seq), TGW'(tag)});
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || expected_releases.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_start(input longint v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= SQW'(v);
		start_seq = SQW'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random traffic: mostly in-window permutations on a few channels
	task automatic random_phase(input int count, input int ch_lo);
		int perm [WIN];
		int n;
		int ch;
		int k;
		int t;
		n = 0;
		while (n < count) begin
			ch = ch_lo + $urandom_range(3);
			if (seen[ch]) begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) perm[i] = i;
				for (int i = k - 1; i > 0; i--) begin
					int j;
					j = $urandom_range(i);
					t = perm[i]; perm[i] = perm[j]; perm[j] = t;
				end
				for (int i = 0; i < k; i++) begin
					add_req(ch, longint'(next_expected[ch]) + perm[i], $urandom);
					n++;
				end
				// pending prediction depends on exact order, so let it settle
				drain();
			end else begin
				add_req(ch, $urandom_range(3) == 0 ? 64'd0 : longint'($urandom), $urandom);
				n++;
				drain();
			end
			if ($urandom_range(9) == 0) begin
				add_req($urandom_range(63), longint'($urandom), $urandom);
				add_req($urandom_range(63), 0, $urandom);
				n += 2;
			end
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: unsequenced, drop, hold, full reorder run, stale, duplicate
		add_req(0, 0, 16'hffff);
		add_req(63, 0, 0);
		add_req(1, 200, 16'h1234);
		add_req(2, 3, 16'h0003);
		add_req(2, 2, 16'h0002);
		add_req(2, 2, 16'h0022);
		for (int i = 16; i >= 4; i--) add_req(2, i, i);
		add_req(2, 17, 17);
		add_req(2, 1, 16'hffff);
		add_req(2, 1, 16'h0000);
		add_req(3, 17, 5);
		drain();

		// wrap past the maximum number
		write_start(pcr_pkg::SEQ_MAX - 1);
		add_req(5, pcr_pkg::SEQ_MAX, 16'haaaa);
		add_req(5, 1, 16'hbbbb);
		add_req(5, pcr_pkg::SEQ_MAX - 1, 16'h5555);
		add_req(5, 2, 16'h7fff);
		drain();
		write_start(0);
		add_req(6, 1, 16'h8000);
		drain();

		// pressure: receiver holds off while requests pile up
		hold_trig++;
		for (int i = 0; i < 30; i++) add_req(10 + i, 0, i);
		drain();

		write_start(1000);
		random_phase(68, 20);
		idle_pct = 46;
		write_start($urandom_range(1, 500));
		random_phase(68, 30);
		idle_pct = 0; stall_pct = 46;
		write_start(1);
		random_phase(68, 40);
		idle_pct = 28; stall_pct = 28;
		write_start(pcr_pkg::SEQ_MAX - 3);
		random_phase(68, 50);

		if (mismatches == 0) begin
			$display("per_channel_resequencer: match");
		end else begin
			$display("per_channel_resequencer: mismatch");
		end
		$finish;
	end

endmodule

// ===== per_channel_resequencer.f =====
hdl/pcr_pkg.sv
hdl/pcr_queue.sv
hdl/pcr_front.sv
hdl/pcr_back.sv
hdl/per_channel_resequencer.sv
verif/tb_top.sv
